// ----- design/tcct_pkg.sv -----
// package for the client connection table: codes, types, widths
// no dependencies
package tcct_pkg;
    localparam int NumEntriesDefault = 8;
    localparam int MaxOut = 8;

    typedef enum logic [2:0] {
        CMD_OPEN = 3'd0, CMD_CONNECT = 3'd1, CMD_DISCONNECT = 3'd2,
        CMD_CLOSE = 3'd3, CMD_RXSEG = 3'd4, CMD_TICK = 3'd5
    } t_cmd;

    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_SYNSENT = 2'd1;
    localparam logic [1:0] ST_CONNECTED = 2'd2;
    localparam logic [1:0] ST_FINWAIT = 2'd3;

    localparam logic [2:0] EV_OK = 3'd0;
    localparam logic [2:0] EV_FAIL = 3'd1;
    localparam logic [2:0] EV_SENT = 3'd2;
    localparam logic [2:0] EV_CONNECTED = 3'd3;
    localparam logic [2:0] EV_SYN_GIVEUP = 3'd4;
    localparam logic [2:0] EV_DISCONNECTED = 3'd5;
    localparam logic [2:0] EV_FIN_GIVEUP = 3'd6;
    localparam logic [2:0] EV_NOTHING = 3'd7;

    localparam logic [1:0] SEG_SYN = 2'd0;
    localparam logic [1:0] SEG_SYNACK = 2'd1;
    localparam logic [1:0] SEG_FIN = 2'd2;
    localparam logic [1:0] SEG_FINACK = 2'd3;

    localparam logic CFG_SYN_LIMIT = 1'b0;
    localparam logic CFG_FIN_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EMIT, S_WAIT, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word, reset scan index
        logic step;      // process the entry under the index, advance
        logic single;    // run the direct command on the selected entry
        logic finish;    // close out a scan command
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_cmd;  // captured command scans the table
        logic scan_end;  // index passed the last entry, the scan hit, or MaxOut results went out
        logic emit;      // a result word is pending
    } t_dp_stat;
endpackage

// ----- design/tcct_ctrl.sv -----
// controller for the client connection table: sequences scans and results
// depends on tcct_pkg
module tcct_ctrl
    import tcct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_out_free) begin
                    n_state = S_SCAN;
                end else if (!i_stat.scan_cmd) begin
                    o_cmd.single = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.scan_end) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- design/tcct_dp.sv -----
// datapath for the client connection table: entry state and result register
// depends on tcct_pkg
module tcct_dp
    import tcct_pkg::*;
#(
    parameter int NUM_ENTRIES = NumEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [3:0]  i_cfg_syn,
    input  logic [3:0]  i_cfg_fin,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_socket_id,
    input  logic [15:0] i_port,
    input  logic [15:0] i_rx_src_port,
    input  logic [15:0] i_rx_dest_port,
    input  logic [1:0]  i_rx_type,
    input  logic [31:0] i_rx_ack_number,
    input  logic        i_out_taken,
    output logic        o_out_valid,
    output logic [2:0]  o_event_res,
    output logic [2:0]  o_entry_id,
    output logic [15:0] o_tx_src_port,
    output logic [15:0] o_tx_dest_port,
    output logic [31:0] o_tx_seq_number,
    output logic [1:0]  o_tx_type,
    output logic        o_last
);
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);

    logic [NUM_ENTRIES-1:0] r_in_use;
    logic [1:0]  r_link [NUM_ENTRIES];
    logic [15:0] r_lport [NUM_ENTRIES];
    logic [15:0] r_rport [NUM_ENTRIES];
    logic [31:0] r_seq [NUM_ENTRIES];
    logic [3:0]  r_sends [NUM_ENTRIES];

    logic [2:0]  r_cmd, r_sid;
    logic [15:0] r_port, r_rsrc, r_rdst;
    logic [1:0]  r_rtype;
    logic [31:0] r_rack;
    logic [CW-1:0] r_idx;
    logic [3:0]  r_nout;
    logic        r_hit;

    logic        r_ov;
    logic [2:0]  r_ev, r_id;
    logic [15:0] r_txs, r_txd;
    logic [31:0] r_txq;
    logic [1:0]  r_txt;
    logic        r_last;

    logic [IW-1:0] cur;
    logic          idx_end;
    logic          sid_ok;
    logic [IW-1:0] s;
    logic          is_scan;

    assign cur = r_idx[IW-1:0];
    assign idx_end = (r_idx == CW'(NUM_ENTRIES));
    assign s = IW'(r_sid);
    assign sid_ok = (int'(r_sid) < NUM_ENTRIES) && r_in_use[s];
    assign is_scan = (r_cmd == CMD_OPEN) || (r_cmd == CMD_RXSEG) || (r_cmd == CMD_TICK);

    assign o_stat.scan_cmd = is_scan;
    assign o_stat.scan_end = idx_end || r_hit || (r_nout == 4'(MaxOut));
    assign o_stat.emit = r_ov;

    always_ff @(posedge i_clk) begin
        logic [1:0] st;
        logic [3:0] lim;
        logic       put;
        logic [2:0] ev;
        logic [2:0] id;
        logic [1:0] tt;
        logic       seg;
        logic       lst;
        st = r_link[cur];
        lim = (st == ST_SYNSENT) ? i_cfg_syn : i_cfg_fin;
        put = 1'b0; ev = EV_NOTHING; id = 3'd0; tt = SEG_SYN; seg = 1'b0; lst = 1'b0;
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_ov <= 1'b0;
            r_idx <= '0;
            r_nout <= '0;
            r_hit <= 1'b0;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                r_link[k] <= ST_CLOSED;
                r_lport[k] <= '0;
                r_rport[k] <= '0;
                r_seq[k] <= '0;
                r_sends[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_cmd <= i_command; r_sid <= i_socket_id; r_port <= i_port;
                r_rsrc <= i_rx_src_port; r_rdst <= i_rx_dest_port;
                r_rtype <= i_rx_type; r_rack <= i_rx_ack_number;
                r_idx <= '0; r_nout <= '0; r_hit <= 1'b0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
                unique case (r_cmd)
                    CMD_OPEN: if (!r_in_use[cur]) begin
                        r_in_use[cur] <= 1'b1; r_link[cur] <= ST_CLOSED;
                        r_lport[cur] <= r_port; r_rport[cur] <= '0;
                        r_seq[cur] <= '0; r_sends[cur] <= '0;
                        r_hit <= 1'b1; put = 1'b1; ev = EV_OK; id = 3'(cur); lst = 1'b1;
                    end
                    CMD_RXSEG: if (r_in_use[cur] && r_lport[cur] == r_rdst
                                   && r_rport[cur] == r_rsrc) begin
                        r_hit <= 1'b1; put = 1'b1; lst = 1'b1;
                        if (r_rtype == SEG_SYNACK && st == ST_SYNSENT) begin
                            r_link[cur] <= ST_CONNECTED; r_seq[cur] <= r_rack;
                            ev = EV_CONNECTED; id = 3'(cur);
                        end else if (r_rtype == SEG_FINACK && st == ST_FINWAIT) begin
                            r_link[cur] <= ST_CLOSED;
                            ev = EV_DISCONNECTED; id = 3'(cur);
                        end
                    end
                    default: if (r_in_use[cur] && (st == ST_SYNSENT || st == ST_FINWAIT)) begin
                        put = 1'b1; id = 3'(cur);
                        r_nout <= r_nout + 1'b1;
                        if (r_sends[cur] < lim) begin
                            r_sends[cur] <= r_sends[cur] + 1'b1;
                            ev = EV_SENT; seg = 1'b1;
                            tt = (st == ST_SYNSENT) ? SEG_SYN : SEG_FIN;
                        end else begin
                            r_link[cur] <= ST_CLOSED;
                            ev = (st == ST_SYNSENT) ? EV_SYN_GIVEUP : EV_FIN_GIVEUP;
                        end
                    end
                endcase
            end
            if (i_cmd.finish) begin
                // scan ended without a hit: open fails, rx and empty tick give nothing;
                // a tick that emitted already closes with a marker-only fix
                if (!r_hit && (r_cmd != CMD_TICK || r_nout == 4'd0)) begin
                    put = 1'b1; lst = 1'b1;
                    ev = (r_cmd == CMD_OPEN) ? EV_FAIL : EV_NOTHING;
                end
            end
            if (i_cmd.single) begin
                put = 1'b1; lst = 1'b1; ev = EV_FAIL; id = r_sid;
                unique case (r_cmd)
                    CMD_CONNECT: if (sid_ok && r_link[s] == ST_CLOSED) begin
                        r_rport[s] <= r_port; r_link[s] <= ST_SYNSENT; r_sends[s] <= 4'd1;
                        ev = EV_SENT; seg = 1'b1; tt = SEG_SYN; id = 3'(s);
                    end
                    CMD_DISCONNECT: if (sid_ok && r_link[s] == ST_CONNECTED) begin
                        r_link[s] <= ST_FINWAIT; r_sends[s] <= 4'd1;
                        ev = EV_SENT; seg = 1'b1; tt = SEG_FIN; id = 3'(s);
                    end
                    CMD_CLOSE: if (sid_ok && r_link[s] == ST_CLOSED) begin
                        r_in_use[s] <= 1'b0; r_sends[s] <= '0;
                        ev = EV_OK; id = 3'(s);
                    end
                    default: id = 3'd0;
                endcase
            end
            if (put) begin
                r_ov <= 1'b1;
                r_ev <= ev; r_id <= id; r_last <= lst;
                r_txs <= seg ? r_lport[i_cmd.single ? s : cur] : 16'd0;
                r_txd <= seg ? (i_cmd.single && r_cmd == CMD_CONNECT ? r_port
                               : r_rport[i_cmd.single ? s : cur]) : 16'd0;
                r_txq <= seg ? r_seq[i_cmd.single ? s : cur] : 32'd0;
                r_txt <= seg ? tt : 2'd0;
            end else if (i_out_taken) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_event_res = r_ev;
    assign o_entry_id = r_id;
    assign o_tx_src_port = r_txs;
    assign o_tx_dest_port = r_txd;
    assign o_tx_seq_number = r_txq;
    assign o_tx_type = r_txt;
    assign o_last = r_last;
endmodule

// ----- design/transport_client_connection_table.sv -----
// top level of the client connection table
// depends on tcct_pkg, tcct_ctrl, tcct_dp
//
// usage
// - slave channel takes one command word; master channel returns one or
//   more result words, the final one flagged by m_axis_tlast
// - commands open, connect, disconnect, close, received segment, tick
// - direct commands (connect, disconnect, close) give one result word
// - open and received segment scan the entries one a cycle, while the
//   output is free, until a hit; tick walks the entries the same way up
//   to MaxOut results, and emits at most one result per entry
// - the next command word is taken the cycle after its last result word is
//   taken
// - the dp result register and the holding stage hold results while the
//   receiver stalls; the scan pauses until the dp word can move on
// - reset clears every entry to free and closed, and both retry limits to 5
// - the user writes retry limits on the plain config port only while idle; the block does not enforce it
// - a tick that ends after emitting results carries tlast on its last word;
//   the last result word is marked by lookahead in the holding stage
module transport_client_connection_table
    import tcct_pkg::*;
#(
    parameter int NUM_ENTRIES = NumEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] command, [5:3] socket_id, [21:6] port, [37:22] rx_src_port,
    // [53:38] rx_dest_port, [55:54] rx_type, [87:56] rx_ack_number
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] event_res, [5:3] entry_id, [21:6] tx_src_port,
    // [37:22] tx_dest_port, [69:38] tx_seq_number, [71:70] tx_type
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    logic [3:0] r_syn_lim, r_fin_lim;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic busy, dv, dl;
    logic [2:0] ev, id;
    logic [15:0] ts, td;
    logic [31:0] tq;
    logic [1:0] tt;
    // holding stage so tlast can be set when a tick ends after emitting results
    logic r_hv, r_hl;
    logic [71:0] r_hd;
    logic take_dp, dp_free;
    logic hold_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_syn_lim <= 4'd5;
            r_fin_lim <= 4'd5;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SYN_LIMIT) r_syn_lim <= i_cfg_data;
            else r_fin_lim <= i_cfg_data;
        end
    end

    assign s_axis_tready = !busy && !dv && !r_hv;

    // the holding word goes out only once its successor or the end is known
    assign hold_go = r_hv && (r_hl || dv || !busy);
    assign m_axis_tvalid = hold_go;
    assign m_axis_tdata = r_hd;
    assign m_axis_tlast = r_hl || (!dv && !busy);

    // hand dp word to holding stage when it is empty or being drained
    assign take_dp = dv && (!r_hv || (hold_go && m_axis_tready));
    // the scan may place a new word when the dp register is empty or moving on
    assign dp_free = !dv || take_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_hl <= 1'b0;
        end else begin
            if (take_dp) begin
                r_hv <= 1'b1;
                r_hl <= dl;
                r_hd <= {tt, tq, td, ts, id, ev};
            end else if (hold_go && m_axis_tready) begin
                r_hv <= 1'b0;
            end
        end
    end

    tcct_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_free(dp_free), .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    tcct_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_cfg_syn(r_syn_lim), .i_cfg_fin(r_fin_lim),
        .i_command(s_axis_tdata[2:0]), .i_socket_id(s_axis_tdata[5:3]),
        .i_port(s_axis_tdata[21:6]), .i_rx_src_port(s_axis_tdata[37:22]),
        .i_rx_dest_port(s_axis_tdata[53:38]), .i_rx_type(s_axis_tdata[55:54]),
        .i_rx_ack_number(s_axis_tdata[87:56]),
        .i_out_taken(take_dp),
        .o_out_valid(dv), .o_event_res(ev), .o_entry_id(id),
        .o_tx_src_port(ts), .o_tx_dest_port(td), .o_tx_seq_number(tq),
        .o_tx_type(tt), .o_last(dl)
    );
endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the client connection table
// depends on tcct_pkg and transport_client_connection_table; keeps its own copy of the table
`timescale 1ns / 1ps

module tb_top
    import tcct_pkg::*;
();

    typedef struct {
        logic [2:0]  ev;
        logic [2:0]  id;
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] seq;
        logic [1:0]  typ;
        logic        last;
    } t_result;

    localparam int NE = 8;
    localparam int CycleLimit = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [87:0] s_data;
    logic        m_valid;
    logic        m_ready;
    logic [71:0] m_data;
    logic        m_last;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    // shadow of the connection table
    logic        sh_used [NE];
    logic [1:0]  sh_state [NE];
    logic [15:0] sh_lport [NE];
    logic [15:0] sh_rport [NE];
    logic [31:0] sh_seq [NE];
    logic [3:0]  sh_sends [NE];
    logic [3:0]  syn_limit;
    logic [3:0]  fin_limit;

    t_result pending_results[$];
    int      errors;
    int      cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_cycles;

    transport_client_connection_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic push_result(logic [2:0] ev, logic [2:0] id, logic [1:0] typ, bit seg);
        t_result r;
        r.ev = ev;
        r.id = id;
        r.src = seg ? sh_lport[id] : 16'd0;
        r.dst = seg ? sh_rport[id] : 16'd0;
        r.seq = seg ? sh_seq[id] : 32'd0;
        r.typ = seg ? typ : 2'd0;
        r.last = 1'b0;
        pending_results.push_back(r);
    endtask

    // expected result words of one accepted command word
    task automatic predict_connection(logic [87:0] w);
        logic [2:0]  cmd;
        logic [2:0]  sid;
        logic [15:0] port;
        logic [15:0] rsrc;
        logic [15:0] rdst;
        logic [1:0]  rtype;
        logic [31:0] rack;
        int          i;
        int          n;
        logic [3:0]  lim;
        cmd = w[2:0];
        sid = w[5:3];
        port = w[21:6];
        rsrc = w[37:22];
        rdst = w[53:38];
        rtype = w[55:54];
        rack = w[87:56];
        n = 0;
        case (cmd)
            CMD_OPEN: begin
                for (i = 0; i < NE && sh_used[i]; i++) begin
                end
                if (i == NE) begin
                    push_result(EV_FAIL, 3'd0, 2'd0, 0);
                end else begin
                    sh_used[i] = 1'b1;
                    sh_state[i] = ST_CLOSED;
                    sh_lport[i] = port;
                    sh_rport[i] = 16'd0;
                    sh_seq[i] = 32'd0;
                    sh_sends[i] = 4'd0;
                    push_result(EV_OK, i[2:0], 2'd0, 0);
                end
            end
            CMD_CONNECT: begin
                if (sh_used[sid] && sh_state[sid] == ST_CLOSED) begin
                    sh_rport[sid] = port;
                    sh_state[sid] = ST_SYNSENT;
                    sh_sends[sid] = 4'd1;
                    push_result(EV_SENT, sid, SEG_SYN, 1);
                end else begin
                    push_result(EV_FAIL, sid, 2'd0, 0);
                end
            end
            CMD_DISCONNECT: begin
                if (sh_used[sid] && sh_state[sid] == ST_CONNECTED) begin
                    sh_state[sid] = ST_FINWAIT;
                    sh_sends[sid] = 4'd1;
                    push_result(EV_SENT, sid, SEG_FIN, 1);
                end else begin
                    push_result(EV_FAIL, sid, 2'd0, 0);
                end
            end
            CMD_CLOSE: begin
                if (sh_used[sid] && sh_state[sid] == ST_CLOSED) begin
                    sh_used[sid] = 1'b0;
                    sh_sends[sid] = 4'd0;
                    push_result(EV_OK, sid, 2'd0, 0);
                end else begin
                    push_result(EV_FAIL, sid, 2'd0, 0);
                end
            end
            CMD_RXSEG: begin
                // first entry in use whose port pair matches
                for (i = 0; i < NE; i++)
                    if (sh_used[i] && sh_lport[i] == rdst && sh_rport[i] == rsrc)
                        break;
                if (i < NE && rtype == SEG_SYNACK && sh_state[i] == ST_SYNSENT) begin
                    sh_state[i] = ST_CONNECTED;
                    sh_seq[i] = rack;
                    push_result(EV_CONNECTED, i[2:0], 2'd0, 0);
                end else if (i < NE && rtype == SEG_FINACK && sh_state[i] == ST_FINWAIT) begin
                    sh_state[i] = ST_CLOSED;
                    push_result(EV_DISCONNECTED, i[2:0], 2'd0, 0);
                end else begin
                    push_result(EV_NOTHING, 3'd0, 2'd0, 0);
                end
            end
            CMD_TICK: begin
                for (i = 0; i < NE && n < MaxOut; i++) begin
                    if (!sh_used[i] || !(sh_state[i] == ST_SYNSENT || sh_state[i] == ST_FINWAIT))
                        continue;
                    lim = (sh_state[i] == ST_SYNSENT) ? syn_limit : fin_limit;
                    n++;
                    if (sh_sends[i] < lim) begin
                        sh_sends[i] = sh_sends[i] + 4'd1;
                        push_result(EV_SENT, i[2:0],
                                    sh_state[i] == ST_SYNSENT ? SEG_SYN : SEG_FIN, 1);
                    end else begin
                        push_result(sh_state[i] == ST_SYNSENT ? EV_SYN_GIVEUP : EV_FIN_GIVEUP,
                                    i[2:0], 2'd0, 0);
                        sh_state[i] = ST_CLOSED;
                    end
                end
                if (n == 0)
                    push_result(EV_NOTHING, 3'd0, 2'd0, 0);
            end
            default: begin
                push_result(EV_FAIL, 3'd0, 2'd0, 0);
            end
        endcase
        pending_results[$].last = 1'b1;
    endtask

    // offers one command word, predicts on acceptance; valid stays high for a following word
    task automatic send_word(logic [2:0] cmd, logic [2:0] sid, logic [15:0] port,
                             logic [15:0] rsrc, logic [15:0] rdst, logic [1:0] rtype,
                             logic [31:0] rack);
        logic [87:0] w;
        w = {rack, rtype, rdst, rsrc, port, sid, cmd};
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_data <= 88'({$urandom, $urandom, $urandom});
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge i_clk); while (!s_ready);
        predict_connection(w);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // a scan may still be closing out
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_limit(logic idx, logic [3:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYN_LIMIT)
            syn_limit = value;
        else
            fin_limit = value;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", m_data);
                errors++;
            end else begin
                r = pending_results.pop_front();
                if (m_data[2:0] !== r.ev) begin
                    $error("event_res exp %0d got %0d", r.ev, m_data[2:0]);
                    errors++;
                end
                if (m_data[5:3] !== r.id) begin
                    $error("entry_id exp %0d got %0d", r.id, m_data[5:3]);
                    errors++;
                end
                if (m_data[21:6] !== r.src) begin
                    $error("tx_src_port exp %h got %h", r.src, m_data[21:6]);
                    errors++;
                end
                if (m_data[37:22] !== r.dst) begin
                    $error("tx_dest_port exp %h got %h", r.dst, m_data[37:22]);
                    errors++;
                end
                if (m_data[69:38] !== r.seq) begin
                    $error("tx_seq_number exp %h got %h", r.seq, m_data[69:38]);
                    errors++;
                end
                if (m_data[71:70] !== r.typ) begin
                    $error("tx_type exp %0d got %0d", r.typ, m_data[71:70]);
                    errors++;
                end
                if (m_last !== r.last) begin
                    $error("last exp %0d got %0d", r.last, m_last);
                    errors++;
                end
            end
        end
    end

    // receiver ready, held low while hold_cycles counts down when a long stall is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one random word, mostly well-formed against the current table
    task automatic random_word();
        int          pick;
        logic [2:0]  sid;
        logic [15:0] port;
        logic [15:0] rsrc;
        logic [15:0] rdst;
        logic [1:0]  rtype;
        pick = $urandom_range(99);
        sid = 3'($urandom_range(7));
        // small port pool so matches and duplicate pairs happen
        port = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3));
        rsrc = 16'($urandom);
        rdst = 16'($urandom);
        rtype = 2'($urandom_range(3));
        if (pick < 60 && $urandom_range(9) < 8) begin
            rsrc = sh_rport[sid];
            rdst = sh_lport[sid];
            rtype = (sh_state[sid] == ST_FINWAIT) ? SEG_FINACK : SEG_SYNACK;
            if ($urandom_range(7) == 0)
                rtype = 2'($urandom_range(3));
        end
        if (pick < 14)
            send_word(CMD_OPEN, sid, port, rsrc, rdst, rtype, $urandom);
        else if (pick < 30)
            send_word(CMD_CONNECT, sid, port, rsrc, rdst, rtype, $urandom);
        else if (pick < 42)
            send_word(CMD_DISCONNECT, sid, port, rsrc, rdst, rtype, $urandom);
        else if (pick < 50)
            send_word(CMD_CLOSE, sid, port, rsrc, rdst, rtype, $urandom);
        else if (pick < 75)
            send_word(CMD_RXSEG, sid, port, rsrc, rdst, rtype, $urandom);
        else if (pick < 97)
            send_word(CMD_TICK, sid, port, rsrc, rdst, rtype, $urandom);
        else
            send_word(3'($urandom_range(7, 6)), sid, port, rsrc, rdst, rtype, $urandom);
    endtask

    task automatic test_directed();
        int i;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);   // empty table tick
        for (i = 0; i < NE; i++)
            send_word(CMD_OPEN, 3'd0, i[0] ? 16'hffff : 16'(i), 16'd0, 16'd0, SEG_SYN, 32'd0);
        send_word(CMD_OPEN, 3'd7, 16'h1234, 16'd0, 16'd0, SEG_SYN, 32'd0);  // table full
        for (i = 0; i < NE; i++)
            send_word(CMD_CONNECT, 3'(i), 16'(16'hffff - i), 16'd0, 16'd0, SEG_SYN, 32'd0);
        send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);    // all eight resend
        // wrong segment type on a matching pair, then the real synack
        send_word(CMD_RXSEG, 3'd0, 16'd0, 16'hffff, 16'd0, SEG_SYN, 32'hffffffff);
        send_word(CMD_RXSEG, 3'd0, 16'd0, 16'hffff, 16'd0, SEG_SYNACK, 32'hffffffff);
        send_word(CMD_RXSEG, 3'd0, 16'd0, 16'h0, 16'h0, SEG_SYNACK, 32'h0);  // no match
        send_word(CMD_DISCONNECT, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);
        send_word(CMD_DISCONNECT, 3'd1, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0); // not connected
        send_word(CMD_RXSEG, 3'd0, 16'd0, 16'hffff, 16'd0, SEG_FIN, 32'd0);
        send_word(CMD_RXSEG, 3'd0, 16'd0, 16'hffff, 16'd0, SEG_FINACK, 32'd0);
        send_word(CMD_CLOSE, 3'd1, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);      // not closed
        send_word(CMD_CLOSE, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);
        send_word(CMD_CLOSE, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);      // already free
        send_word(3'd6, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);
        send_word(3'd7, 3'd7, 16'hffff, 16'hffff, 16'hffff, SEG_FINACK, 32'hffffffff);
        drain_results();
    endtask

    // a zero syn limit makes the next tick give up on every entry waiting on a syn
    task automatic test_limits_extreme();
        int i;
        write_limit(CFG_SYN_LIMIT, 4'd0);
        write_limit(CFG_FIN_LIMIT, 4'd15);
        for (i = 0; i < 4; i++)
            send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);
        write_limit(CFG_SYN_LIMIT, 4'd15);
        for (i = 0; i < 18; i++)
            send_word(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0, SEG_SYN, 32'd0);
        drain_results();
    endtask

    task automatic test_random_phase(int idle, int stall, logic [3:0] syn, logic [3:0] fin,
                                     int count);
        int i;
        write_limit(CFG_SYN_LIMIT, syn);
        write_limit(CFG_FIN_LIMIT, fin);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (i = 0; i < count; i++)
            random_word();
        drain_results();
    endtask

    // receiver holds off while words keep coming, so the input stalls
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        for (i = 0; i < 30; i++)
            random_word();
        drain_results();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        syn_limit = 4'd5;
        fin_limit = 4'd5;
        for (int i = 0; i < NE; i++) begin
            sh_used[i] = 1'b0;
            sh_state[i] = ST_CLOSED;
            sh_lport[i] = '0;
            sh_rport[i] = '0;
            sh_seq[i] = '0;
            sh_sends[i] = '0;
        end
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_limits_extreme();
        test_random_phase(0, 0, 4'd5, 4'd5, 120);
        test_random_phase(77, 0, 4'd1, 4'd15, 110);
        test_random_phase(0, 77, 4'd15, 4'd1, 110);
        test_random_phase(27, 27, 4'd3, 4'd2, 110);
        test_backpressure();

        drain_results();
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
